### hw/rtl/b64d_pkg.sv
// ============================================================================
// b64d_pkg
// Shared types, status codes and the character decode for the strict base64
// decoder.
// ============================================================================
package b64d_pkg;

   // status codes carried on the final response
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_LENGTH  = 3'd1;
   localparam logic [2:0] ST_PAD     = 3'd2;
   localparam logic [2:0] ST_CHAR    = 3'd3;
   localparam logic [2:0] ST_PADBITS = 3'd4;

   // sextet code for a character outside the alphabet
   localparam logic [6:0] NO_SEXTET  = 7'd64;
   localparam logic [7:0] PAD_CHAR   = 8'h3D;

   // response queue sizing: one request can add up to three responses
   localparam int         MAX_RSP    = 3;
   localparam int         QUEUE_DEPTH = 6;
   localparam int         PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int         CNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       final_result;
      logic [2:0] status;
   } rsp_type;

   // map an ascii code to its sextet, or NO_SEXTET
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] v;
      if (c >= 8'h41 && c <= 8'h5A) begin
         v = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         v = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 7'd62;
      end else if (c == 8'h2F) begin
         v = 7'd63;
      end else begin
         v = NO_SEXTET;
      end
      return v;
   endfunction

endpackage

### hw/rtl/strict_base64_decoder.sv
// ============================================================================
// strict_base64_decoder
// Strict base64 decoder: one character per request, one to three bytes per
// completed group, first error latched and reported on the final response.
// ============================================================================
// responses are registered: written into the queue when the request is accepted
// throughput: while rsp_stall is low, one character per cycle sustained; a group
//   of four characters gives at most three responses, drained one per cycle from
//   a six-entry queue; req_stall is raised while it holds over three responses
// reset (synchronous, active high) clears the group state and empties the queue
module strict_base64_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b64d_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b64d_pkg::rsp_type rsp_data
);

   // decoder state
   logic [1:0]  gpos_ff, gpos_in;
   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pmode_ff, pmode_in;
   logic        pdone_ff, pdone_in;
   logic [2:0]  err_ff, err_in;

   // response queue
   b64d_pkg::rsp_type               queue_ff [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::PTR_W-1:0]      wptr_ff, wptr_in;
   logic [b64d_pkg::PTR_W-1:0]      rptr_ff, rptr_in;
   logic [b64d_pkg::CNT_W-1:0]      count_ff, count_in;

   logic              accept;
   logic              pop;
   logic [1:0]        nres;
   b64d_pkg::rsp_type res [b64d_pkg::MAX_RSP];
   logic [b64d_pkg::PTR_W-1:0] widx [b64d_pkg::MAX_RSP];

   // wrap a pointer plus offset into the queue depth
   function automatic logic [b64d_pkg::PTR_W-1:0] wrap_add(
      input logic [b64d_pkg::PTR_W-1:0] p,
      input logic [1:0]                 k
   );
      logic [b64d_pkg::PTR_W:0] s;
      s = {1'b0, p} + (b64d_pkg::PTR_W+1)'(k);
      if (s >= (b64d_pkg::PTR_W+1)'(b64d_pkg::QUEUE_DEPTH)) begin
         s = s - (b64d_pkg::PTR_W+1)'(b64d_pkg::QUEUE_DEPTH);
      end
      return s[b64d_pkg::PTR_W-1:0];
   endfunction

   // handshakes
   assign req_stall = (count_ff > b64d_pkg::CNT_W'(b64d_pkg::QUEUE_DEPTH - b64d_pkg::MAX_RSP));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = queue_ff[rptr_ff];

   // decode one character against the group state
   always_comb begin
      logic [6:0]  v;
      logic [1:0]  pads;
      logic        complete;
      logic [23:0] t;
      logic [1:0]  newpos;
      logic [2:0]  status;
      gpos_in  = gpos_ff;
      acc_in   = acc_ff;
      pmode_in = pmode_ff;
      pdone_in = pdone_ff;
      err_in   = err_ff;
      v        = '0;
      pads     = '0;
      complete = 1'b0;
      nres     = '0;
      t        = '0;
      status   = b64d_pkg::ST_OK;
      for (int k = 0; k < b64d_pkg::MAX_RSP; k++) begin
         res[k] = '0;
      end

      if (err_ff == b64d_pkg::ST_OK) begin
         if (pdone_ff) begin
            err_in = b64d_pkg::ST_PAD;
         end else if (req_data.char_code == b64d_pkg::PAD_CHAR) begin
            if (gpos_ff < 2'd2) begin
               err_in = b64d_pkg::ST_PAD;
            end else if (gpos_ff == 2'd2) begin
               pmode_in = 2'd1;
               acc_in   = {acc_ff[11:0], 6'd0};
            end else begin
               pads     = pmode_ff + 2'd1;
               complete = 1'b1;
            end
         end else if (pmode_ff != 2'd0) begin
            err_in = b64d_pkg::ST_PAD;
         end else begin
            v = b64d_pkg::sextet_of(req_data.char_code);
            if (v == b64d_pkg::NO_SEXTET) begin
               err_in = b64d_pkg::ST_CHAR;
            end else if (gpos_ff < 2'd3) begin
               acc_in = {acc_ff[11:0], v[5:0]};
            end else begin
               complete = 1'b1;
            end
         end

         // group closed: check discarded bits, emit bytes
         if (complete) begin
            t = {acc_ff, v[5:0]};
            if (pads == 2'd2 && acc_ff[9:6] != 4'd0) begin
               err_in = b64d_pkg::ST_PADBITS;
            end else if (pads == 2'd1 && acc_ff[1:0] != 2'd0) begin
               err_in = b64d_pkg::ST_PADBITS;
            end else begin
               res[0].data_byte  = t[23:16];
               res[0].byte_valid = 1'b1;
               res[1].data_byte  = t[15:8];
               res[1].byte_valid = 1'b1;
               res[2].data_byte  = t[7:0];
               res[2].byte_valid = 1'b1;
               nres = 2'd3 - pads;
            end
            if (pads != 2'd0) begin
               pdone_in = 1'b1;
            end
            pmode_in = 2'd0;
            acc_in   = '0;
         end
      end

      newpos  = gpos_ff + 2'd1;
      gpos_in = newpos;

      // last character: attach status and clear for the next string
      if (req_data.end_of_text) begin
         status = (newpos != 2'd0) ? b64d_pkg::ST_LENGTH : err_in;
         if (status != b64d_pkg::ST_OK) begin
            nres = 2'd0;
         end
         if (nres == 2'd0) begin
            res[0] = '0;
            nres   = 2'd1;
         end
         res[nres - 2'd1].final_result = 1'b1;
         res[nres - 2'd1].status       = status;
         gpos_in  = '0;
         acc_in   = '0;
         pmode_in = '0;
         pdone_in = 1'b0;
         err_in   = b64d_pkg::ST_OK;
      end
   end

   // queue pointer and count update
   always_comb begin
      for (int k = 0; k < b64d_pkg::MAX_RSP; k++) begin
         widx[k] = wrap_add(wptr_ff, 2'(k));
      end
      wptr_in  = accept ? wrap_add(wptr_ff, nres) : wptr_ff;
      rptr_in  = pop ? wrap_add(rptr_ff, 2'd1) : rptr_ff;
      count_in = count_ff + (accept ? b64d_pkg::CNT_W'(nres) : '0)
                 - (pop ? b64d_pkg::CNT_W'(1) : '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gpos_ff  <= '0;
         acc_ff   <= '0;
         pmode_ff <= '0;
         pdone_ff <= 1'b0;
         err_ff   <= b64d_pkg::ST_OK;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            gpos_ff  <= gpos_in;
            acc_ff   <= acc_in;
            pmode_ff <= pmode_in;
            pdone_ff <= pdone_in;
            err_ff   <= err_in;
         end
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // queue payload writes
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < b64d_pkg::MAX_RSP; k++) begin
            if (2'(k) < nres) begin
               queue_ff[widx[k]] <= res[k];
            end
         end
      end
   end

endmodule

### hw/rtl/b64d_checker.sv
// ============================================================================
// b64d_checker
// Port-level checks on the request and response streams of the strict base64
// decoder.
// ============================================================================
module b64d_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input b64d_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input b64d_pkg::rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an empty response only ever closes a string
   a_empty_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.final_result)
      else $error("empty response that is not final");

   // status is reported on the final response only
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.final_result |-> rsp_data.status == b64d_pkg::ST_OK)
      else $error("status on a non-final response");

   // a failed string closes without a byte
   a_err_nobyte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.final_result && rsp_data.status != b64d_pkg::ST_OK
      |-> !rsp_data.byte_valid)
      else $error("byte on a failing final response");

   // a stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

endmodule

bind strict_base64_decoder b64d_checker u_b64d_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### verif/tb_strict_base64_decoder.sv
// ============================================================================
// tb_strict_base64_decoder
// Self-checking bench for the strict base64 decoder. A driver sends characters
// from a queue of pending requests; a monitor predicts the decoded bytes and
// the final status of every string and checks each response in order.
// ============================================================================
module tb_strict_base64_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE      = 10;
   localparam int RANDOM_CHARS = 125;
   localparam bit [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic              drain_first;
      b64d_pkg::req_type item;
   } send_entry_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   b64d_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   b64d_pkg::rsp_type rsp_data;

   send_entry_type    send_q[$];
   b64d_pkg::rsp_type want_rsp[$];
   b64d_pkg::rsp_type exp_rsp;

   // decoder state as predicted
   logic [1:0]  grp_pos;
   logic [17:0] sextets;
   logic        pad_seen;
   logic        pad_closed;
   logic [2:0]  err_code;

   int fails = 0;
   int n_chars = 0;
   int n_texts = 0;
   int n_bytes = 0;
   int n_bad = 0;
   int cyc = 0;
   int stuck = 0;
   logic quiet;

   strict_base64_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      return ALPHABET[8*(63 - int'(idx)) +: 8];
   endfunction

   // sextet of a character by alphabet search, bit 6 set when not found
   function automatic logic [6:0] sextet_code(input logic [7:0] c);
      logic [6:0] code;
      code = b64d_pkg::NO_SEXTET;
      for (int i = 0; i < 64; i++) begin
         if (b64_char(6'(i)) == c) code = 7'(i);
      end
      return code;
   endfunction

   task automatic clear_group();
      grp_pos    = 2'd0;
      sextets    = 18'd0;
      pad_seen   = 1'b0;
      pad_closed = 1'b0;
      err_code   = b64d_pkg::ST_OK;
   endtask

   // advance the predicted state by one character, queue the responses it gives
   task automatic decode_char(input b64d_pkg::req_type r);
      b64d_pkg::rsp_type grp[$];
      b64d_pkg::rsp_type one;
      logic [6:0]  code;
      logic [1:0]  n_pads;
      logic        closes;
      logic [23:0] word;
      logic [2:0]  st;
      n_pads = 2'd0;
      closes = 1'b0;
      code   = 7'd0;
      if (err_code == b64d_pkg::ST_OK) begin
         if (pad_closed) begin
            err_code = b64d_pkg::ST_PAD;
         end else if (r.char_code == b64d_pkg::PAD_CHAR) begin
            if (grp_pos < 2'd2) begin
               err_code = b64d_pkg::ST_PAD;
            end else if (grp_pos == 2'd2) begin
               pad_seen = 1'b1;
               sextets  = {sextets[11:0], 6'd0};
            end else begin
               n_pads = pad_seen ? 2'd2 : 2'd1;
               closes = 1'b1;
            end
         end else if (pad_seen) begin
            err_code = b64d_pkg::ST_PAD;
         end else begin
            code = sextet_code(r.char_code);
            if (code[6]) begin
               err_code = b64d_pkg::ST_CHAR;
            end else if (grp_pos < 2'd3) begin
               sextets = {sextets[11:0], code[5:0]};
            end else begin
               closes = 1'b1;
            end
         end
         // group complete: check discarded bits, then emit bytes
         if (closes) begin
            word = {sextets, code[5:0]};
            if (n_pads == 2'd2 && sextets[9:6] != 4'd0) begin
               err_code = b64d_pkg::ST_PADBITS;
            end else if (n_pads == 2'd1 && sextets[1:0] != 2'd0) begin
               err_code = b64d_pkg::ST_PADBITS;
            end else begin
               one = '0;
               one.byte_valid = 1'b1;
               one.data_byte = word[23:16];
               grp.insert(grp.size(), one);
               if (n_pads < 2'd2) begin
                  one.data_byte = word[15:8];
                  grp.insert(grp.size(), one);
               end
               if (n_pads < 2'd1) begin
                  one.data_byte = word[7:0];
                  grp.insert(grp.size(), one);
               end
            end
            if (n_pads != 2'd0) pad_closed = 1'b1;
            pad_seen = 1'b0;
            sextets  = 18'd0;
         end
      end
      grp_pos = grp_pos + 2'd1;
      // last character: status on the final response, length error wins
      if (r.end_of_text) begin
         st = (grp_pos != 2'd0) ? b64d_pkg::ST_LENGTH : err_code;
         if (st != b64d_pkg::ST_OK) grp.delete();
         if (grp.size() == 0) begin
            one = '0;
            grp.insert(grp.size(), one);
         end
         grp[grp.size() - 1].final_result = 1'b1;
         grp[grp.size() - 1].status = st;
         clear_group();
      end
      foreach (grp[i]) want_rsp.insert(want_rsp.size(), grp[i]);
   endtask

   task automatic queue_char(input logic [7:0] c, input logic eot, input logic drain);
      send_entry_type e;
      e.drain_first = drain;
      e.item.char_code = c;
      e.item.end_of_text = eot;
      send_q.insert(send_q.size(), e);
   endtask

   task automatic add_text(input string s, input logic drain);
      for (int i = 0; i < s.len(); i++) begin
         queue_char(s[i], i == s.len() - 1, drain && i == 0);
      end
   endtask

   // one random string: mostly well formed, some corrupted, some noise
   task automatic add_random_text();
      logic [7:0] txt[$];
      int n_groups;
      int n_pads;
      int len;
      logic [5:0] s;
      logic dirty_bits;
      logic drain;
      if ($urandom_range(99) < 72) begin
         n_pads   = $urandom_range(2);
         n_groups = $urandom_range(2);
         if (n_groups == 0 && n_pads == 0) n_groups = 1;
         repeat (n_groups * 4) txt.insert(txt.size(), b64_char(6'($urandom_range(63))));
         dirty_bits = ($urandom_range(5) == 0);
         if (n_pads == 2) begin
            txt.insert(txt.size(), b64_char(6'($urandom_range(63))));
            s = 6'($urandom_range(63));
            if (!dirty_bits) s[3:0] = 4'd0;
            txt.insert(txt.size(), b64_char(s));
            txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
            txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
         end else if (n_pads == 1) begin
            txt.insert(txt.size(), b64_char(6'($urandom_range(63))));
            txt.insert(txt.size(), b64_char(6'($urandom_range(63))));
            s = 6'($urandom_range(63));
            if (!dirty_bits) s[1:0] = 2'd0;
            txt.insert(txt.size(), b64_char(s));
            txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
         end
         // padded group that is not the last one
         if (n_pads != 0 && $urandom_range(9) == 0) begin
            repeat (4) txt.insert(txt.size(), b64_char(6'($urandom_range(63))));
         end
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
               0: txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
               1: txt[$urandom_range(txt.size() - 1)] = b64d_pkg::PAD_CHAR;
               default: txt.delete(txt.size() - 1);
            endcase
         end
      end else begin
         len = $urandom_range(8, 1);
         repeat (len) begin
            case ($urandom_range(2))
               0: txt.insert(txt.size(), 8'($urandom_range(255)));
               1: txt.insert(txt.size(), b64_char(6'($urandom_range(63))));
               default: txt.insert(txt.size(), b64d_pkg::PAD_CHAR);
            endcase
         end
      end
      drain = ($urandom_range(7) == 0);
      foreach (txt[i]) queue_char(txt[i], i == txt.size() - 1, drain && i == 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || !req_stall) begin
         if (send_q.size() != 0 && !(!quiet && $urandom_range(99) < 6) &&
             !(send_q[0].drain_first && (req_valid || want_rsp.size() != 0))) begin
            req_valid <= 1'b1;
            req_data  <= send_q[0].item;
            send_q.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && $urandom_range(99) < 6;
      end
   end

   // monitor: predict on accepted requests, then check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_char(req_data);
            n_chars++;
            if (req_data.end_of_text) n_texts++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (want_rsp.size() == 0) begin
               $error("unexpected response %h", rsp_data);
               fails++;
            end else begin
               exp_rsp = want_rsp[0];
               want_rsp.delete(0);
               if (rsp_data.data_byte !== exp_rsp.data_byte) begin
                  $error("data_byte: expected %0h, got %0h",
                         exp_rsp.data_byte, rsp_data.data_byte);
                  fails++;
               end
               if (rsp_data.byte_valid !== exp_rsp.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b",
                         exp_rsp.byte_valid, rsp_data.byte_valid);
                  fails++;
               end
               if (rsp_data.final_result !== exp_rsp.final_result) begin
                  $error("final_result: expected %0b, got %0b",
                         exp_rsp.final_result, rsp_data.final_result);
                  fails++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d",
                         exp_rsp.status, rsp_data.status);
                  fails++;
               end
               if (exp_rsp.byte_valid) n_bytes++;
               if (exp_rsp.final_result && exp_rsp.status != b64d_pkg::ST_OK) n_bad++;
            end
         end
      end
   end

   // cycle count, quiet window and watchdog on lack of progress
   assign quiet = (cyc >= 120 && cyc < 260);

   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
      end
      if (stuck >= STUCK_LIMIT) begin
         $display("no handshake for %0d cycles", STUCK_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clear_group();
      // directed strings
      add_text("+/9z", 1'b0);
      add_text("TWE==AAA", 1'b0);
      add_text("TR==", 1'b1);
      add_text("A=", 1'b0);
      queue_char(8'hFF, 1'b0, 1'b0);
      queue_char(8'h00, 1'b1, 1'b0);
      add_text("TW=!", 1'b0);
      add_text("!", 1'b0);
      // random strings
      begin : fill_random
         int base;
         base = send_q.size();
         while (send_q.size() - base < RANDOM_CHARS) add_random_text();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (send_q.size() != 0 || req_valid || want_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (want_rsp.size() != 0) begin
         $error("%0d responses never arrived", want_rsp.size());
         fails++;
      end
      $display("sent %0d characters in %0d strings", n_chars, n_texts);
      $display("checked %0d decoded bytes, %0d strings ended with an error", n_bytes, n_bad);
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
